// ===== rtl/core/alog_pkg.sv =====
// ----------------------------------------------------------------------------
// alog_pkg
// Shared types and constants for the altitude launch logger.
// ----------------------------------------------------------------------------
package alog_pkg;

    localparam int SLOT_COUNT  = 31;
    localparam int DIGIT_COUNT = 5;

    localparam int ALT_W     = 16;
    localparam int THR_W     = 8;
    localparam int SLOTS_W   = 5;
    localparam int BLINK_W   = 4;
    localparam int ADDR_W    = $clog2(SLOT_COUNT);
    localparam int SLOT_W    = $clog2(SLOT_COUNT + 1);
    localparam int DIGIT_W   = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAUNCH_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLEAR_VALUE      = 1'd1;

    localparam logic [THR_W-1:0] THR_RESET   = 8'd2;
    localparam logic [ALT_W-1:0] CLEAR_RESET = 16'd1000;

    // operation codes
    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_READOUT = 1'b1;

    // x / 10 == (x * 52429) >> 19 for any 16-bit x
    localparam logic [16:0] DIV10_MULT  = 17'd52429;
    localparam int          DIV10_SHIFT = 19;
    localparam logic [BLINK_W-1:0] BLINK_ZERO = 4'd10;

    typedef struct packed {
        logic             operation;
        logic [ALT_W-1:0] altitude;
    } alog_in_t;

    typedef struct packed {
        logic [ALT_W-1:0]   filtered_altitude;
        logic               launched;
        logic               led_on;
        logic [SLOTS_W-1:0] slots_used;
        logic [BLINK_W-1:0] blink_count;
        logic               last;
    } alog_out_t;

    // requests from the control logic to the log store
    typedef struct packed {
        logic              clear;
        logic [ALT_W-1:0]  fill;
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [ALT_W-1:0]  wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } alog_store_req_t;

endpackage

// ===== rtl/core/alog_store.sv =====
// ----------------------------------------------------------------------------
// alog_store
// Log slot memory with registered read. Per-slot valid bits stand
// in for the reset and launch fills: an unwritten slot reads the fill value.
// ----------------------------------------------------------------------------
module alog_store
    import alog_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  alog_store_req_t       req,
    output logic [ALT_W-1:0]      rdata
);

    logic [ALT_W-1:0]      mem [SLOT_COUNT];
    logic [ALT_W-1:0]      ram_q_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] valid_next;
    logic                  hit_reg;
    logic [ALT_W-1:0]      fill_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (req.clear)
        begin
            valid_next = '0;
        end
        if (req.we)
        begin
            valid_next[req.waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
            fill_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (req.clear)
            begin
                fill_reg <= req.fill;
            end
            if (req.re)
            begin
                hit_reg <= valid_reg[req.raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            ram_q_reg <= mem[req.raddr];
        end
    end

    assign rdata = hit_reg ? ram_q_reg : fill_reg;

endmodule

// ===== rtl/core/altitude_launch_logger.sv =====
// ----------------------------------------------------------------------------
// altitude_launch_logger
// Filters altitude samples, detects launch, logs filtered values and reads
// the maximum logged value back as decimal blink counts.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+--------------------------------------
//  in       | in_valid / in_stall | in_data   (operation, altitude)
//  out      | out_valid/out_stall | out_data  (filtered value, status, digit)
//  cfg      | cfg_we              | cfg_index, cfg_data
//
//  Sample: one result beat, loaded into the output register.
//  Readout: walks the store through its single read port, loads the digit
//  work value, then emits the digit beats (DIGIT_COUNT beats, or none if
//  max 0).
//  Reset: store reads zero through per-slot valid bits; no clearing pass.
//  A new item is taken while idle and the output register is free or
//  emptying in the same cycle; out_stall holds digit emission.
// ----------------------------------------------------------------------------
module altitude_launch_logger
    import alog_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  alog_in_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output alog_out_t            out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd2;
    localparam logic [1:0] ST_DIGIT = 2'd3;

    logic [THR_W-1:0]   thr_reg;
    logic [ALT_W-1:0]   clr_reg;
    logic [ALT_W-1:0]   filt_reg,  filt_next;
    logic               primed_reg, primed_next;
    logic               launch_seen_reg, launch_seen_next;
    logic               led_reg,   led_next;
    logic [SLOT_W-1:0]  wslot_reg, wslot_next;
    logic [1:0]         state_reg, state_next;
    logic [SLOT_W-1:0]  scan_reg,  scan_next;
    logic               rd_pend_reg;
    logic [ALT_W-1:0]   max_reg,   max_next;
    logic [ALT_W-1:0]   work_reg,  work_next;
    logic [DIGIT_W-1:0] digit_reg, digit_next;
    logic               out_valid_reg, out_valid_next;
    alog_out_t          out_data_reg,  out_data_next;

    alog_store_req_t    sreq;
    logic [ALT_W-1:0]   srdata;

    logic               in_accept;
    logic               out_free;
    logic [ALT_W:0]     sum;
    logic [ALT_W-1:0]   nv;
    logic [ALT_W:0]     limit;
    logic               launch_now;
    logic               launch_after;
    logic [SLOT_W-1:0]  slot_base;
    logic               log_now;
    logic [32:0]        prod;
    logic [ALT_W-1:0]   quot;
    logic [ALT_W-1:0]   rem_full;
    logic [BLINK_W-1:0] rem;

    alog_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sreq),
        .rdata (srdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != ST_IDLE) || !out_free;
    assign in_accept = in_valid && !in_stall;

    // sample datapath
    assign sum          = {1'b0, in_data.altitude} + {1'b0, filt_reg};
    assign nv           = sum[ALT_W:1];
    assign limit        = {1'b0, filt_reg} + (ALT_W + 1)'(thr_reg);
    assign launch_now   = primed_reg && !launch_seen_reg && ({1'b0, nv} > limit);
    assign launch_after = launch_seen_reg || launch_now;
    assign slot_base    = launch_now ? '0 : wslot_reg;
    assign log_now      = primed_reg && launch_after && (slot_base < SLOT_W'(SLOT_COUNT));

    // one decimal digit per step
    assign prod     = {1'b0, work_reg} * {16'd0, DIV10_MULT};
    assign quot     = ALT_W'(prod >> DIV10_SHIFT);
    assign rem_full = work_reg - ((quot << 3) + (quot << 1));
    assign rem      = rem_full[BLINK_W-1:0];

    always_comb
    begin
        filt_next        = filt_reg;
        primed_next      = primed_reg;
        launch_seen_next = launch_seen_reg;
        led_next         = led_reg;
        wslot_next       = wslot_reg;
        state_next       = state_reg;
        scan_next        = scan_reg;
        max_next         = max_reg;
        work_next        = work_reg;
        digit_next       = digit_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_data_next    = out_data_reg;

        sreq       = '0;
        sreq.fill  = clr_reg;
        sreq.wdata = nv;
        sreq.waddr = slot_base[ADDR_W-1:0];
        sreq.raddr = scan_reg[ADDR_W-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_data.operation == OP_READOUT)
                    begin
                        state_next = ST_SCAN;
                        scan_next  = '0;
                        max_next   = '0;
                    end
                    else
                    begin
                        if (!primed_reg)
                        begin
                            filt_next   = in_data.altitude;
                            primed_next = 1'b1;
                        end
                        else
                        begin
                            filt_next        = nv;
                            launch_seen_next = launch_after;
                            led_next         = !launch_after && !led_reg;
                            sreq.clear       = launch_now;
                            sreq.we          = log_now;
                            wslot_next       = log_now ? slot_base + 1'b1 : slot_base;
                        end
                        out_valid_next                  = 1'b1;
                        out_data_next.filtered_altitude = filt_next;
                        out_data_next.launched          = launch_seen_next;
                        out_data_next.led_on            = led_next;
                        out_data_next.slots_used        = SLOTS_W'(wslot_next);
                        out_data_next.blink_count       = '0;
                        out_data_next.last              = 1'b1;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rd_pend_reg && (srdata > max_reg))
                begin
                    max_next = srdata;
                end
                if (scan_reg < SLOT_W'(SLOT_COUNT))
                begin
                    sreq.re   = 1'b1;
                    scan_next = scan_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                work_next  = max_reg;
                digit_next = '0;
                state_next = (max_reg == '0) ? ST_IDLE : ST_DIGIT;
            end

            ST_DIGIT:
            begin
                if (out_free)
                begin
                    out_valid_next                  = 1'b1;
                    out_data_next.filtered_altitude = filt_reg;
                    out_data_next.launched          = launch_seen_reg;
                    out_data_next.led_on            = led_reg;
                    out_data_next.slots_used        = SLOTS_W'(wslot_reg);
                    out_data_next.blink_count       = (rem == '0) ? BLINK_ZERO : rem;
                    out_data_next.last              =
                        (digit_reg == DIGIT_W'(DIGIT_COUNT - 1));
                    work_next  = quot;
                    digit_next = digit_reg + 1'b1;
                    if (digit_reg == DIGIT_W'(DIGIT_COUNT - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg         <= THR_RESET;
            clr_reg         <= CLEAR_RESET;
            filt_reg        <= '0;
            primed_reg      <= 1'b0;
            launch_seen_reg <= 1'b0;
            led_reg         <= 1'b0;
            wslot_reg       <= '0;
            state_reg       <= ST_IDLE;
            scan_reg        <= '0;
            rd_pend_reg     <= 1'b0;
            digit_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LAUNCH_THRESHOLD: thr_reg <= cfg_data[THR_W-1:0];
                    REG_CLEAR_VALUE:      clr_reg <= cfg_data[ALT_W-1:0];
                    default:              ;
                endcase
            end
            filt_reg        <= filt_next;
            primed_reg      <= primed_next;
            launch_seen_reg <= launch_seen_next;
            led_reg         <= led_next;
            wslot_reg       <= wslot_next;
            state_reg       <= state_next;
            scan_reg        <= scan_next;
            rd_pend_reg     <= sreq.re;
            digit_reg       <= digit_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_reg      <= max_next;
        work_reg     <= work_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // launch is sticky and forces the LED off
    a_launch_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        launch_seen_reg |=> launch_seen_reg)
        else $error("launch flag dropped");

    a_led_off_after_launch: assert property (@(posedge clk) disable iff (!rst_n)
        launch_seen_reg |-> !led_reg)
        else $error("LED on after launch");

    a_slot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wslot_reg <= SLOT_W'(SLOT_COUNT))
        else $error("write slot past end of store");

    a_log_needs_launch: assert property (@(posedge clk) disable iff (!rst_n)
        (wslot_reg != '0) |-> launch_seen_reg)
        else $error("slots logged before launch");

endmodule
